@@ src/gfov_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfov_pkg: shared types and constants of the grid field-of-view engine
// Map limits, item structs, mode and register codes, and the command/status
// bundles between controller and datapath.
// ---------------------------------------------------------------------------
package gfov_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELLS);

	localparam int X_W   = 6;   // cell_x field
	localparam int Y_W   = 6;   // cell_y field
	localparam int CFG_W = 7;   // config data
	localparam int IDX_W = 2;   // config register index

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_VIEW  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		mode_t          mode;
		logic [X_W-1:0] cell_x;
		logic [Y_W-1:0] cell_y;
		logic           see_through;
	} item_in_t;

	typedef struct packed {
		logic is_visible;
		logic is_explored;
		logic bad_coord;
	} item_out_t;

	typedef struct packed {
		logic sweep_init;   // reset clearing pass
		logic sweep_clear;  // visible clear at view start
		logic capture;
		logic load_tile;
		logic query_rd;
		logic mark_viewer;
		logic ray_init;
		logic step;
		logic check_rd;
		logic mark_ray;
		logic next_target;
		logic out_load;
		logic out_query;
		logic out_bad;
	} gfov_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  in_bad;
		logic  out_busy;
		logic  sweep_last;
		logic  radius_neg;
		logic  check_stop;
		logic  mark_stop;
		logic  target_last;
	} gfov_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
	endfunction

endpackage
`default_nettype wire

@@ src/gfov_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfov_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module gfov_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ src/gfov_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfov_ctrl: controller of the field-of-view engine
// Sequences reset clear, loads, queries and the ray walk of a view item.
// ---------------------------------------------------------------------------
module gfov_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire gfov_pkg::gfov_stat_t st,
	output      gfov_pkg::gfov_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_INIT   = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_QRESP  = 10'b0000000100,
		S_CLEAR  = 10'b0000001000,
		S_VIEWER = 10'b0000010000,
		S_RAYINIT= 10'b0000100000,
		S_STEP   = 10'b0001000000,
		S_CHECK  = 10'b0010000000,
		S_MARK   = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep_init = 1'b1;
				if (st.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = !st.out_busy;
				if (in_valid && !st.out_busy) begin
					if (st.mode == gfov_pkg::MODE_NONE) begin
						cmd.out_load = 1'b1;
					end else if (st.in_bad) begin
						cmd.out_load = 1'b1;
						cmd.out_bad  = 1'b1;
					end else if (st.mode == gfov_pkg::MODE_LOAD) begin
						cmd.load_tile = 1'b1;
						cmd.out_load  = 1'b1;
					end else if (st.mode == gfov_pkg::MODE_VIEW) begin
						cmd.capture = 1'b1;
						state_d     = S_CLEAR;
					end else begin
						cmd.query_rd = 1'b1;
						state_d      = S_QRESP;
					end
				end
			end
			S_QRESP: begin
				cmd.out_load  = 1'b1;
				cmd.out_query = 1'b1;
				state_d       = S_IDLE;
			end
			S_CLEAR: begin
				cmd.sweep_clear = 1'b1;
				if (st.sweep_last) begin
					state_d = st.radius_neg ? S_DONE : S_VIEWER;
				end
			end
			S_VIEWER: begin
				cmd.mark_viewer = 1'b1;
				state_d         = S_RAYINIT;
			end
			S_RAYINIT: begin
				cmd.ray_init = 1'b1;
				state_d      = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				cmd.check_rd = 1'b1;
				if (st.check_stop) begin
					cmd.next_target = 1'b1;
					state_d         = st.target_last ? S_DONE : S_RAYINIT;
				end else begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				cmd.mark_ray = 1'b1;
				if (st.mark_stop) begin
					cmd.next_target = 1'b1;
					state_d         = st.target_last ? S_DONE : S_RAYINIT;
				end else begin
					state_d = S_STEP;
				end
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ src/gfov_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gfov_dp: datapath of the field-of-view engine
// Config registers, the three cell stores, sweep counters, Bresenham
// stepper, distance check and the result register.
// ---------------------------------------------------------------------------
module gfov_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gfov_pkg::item_in_t                   in_data,
	output      gfov_pkg::item_out_t                  out_data,
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic                                 cfg_we,
	input  wire logic [gfov_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [gfov_pkg::CFG_W-1:0]           cfg_data,
	input  wire gfov_pkg::gfov_cmd_t                  cmd,
	output      gfov_pkg::gfov_stat_t                 st
);

	localparam int XW = gfov_pkg::X_W;
	localparam int YW = gfov_pkg::Y_W;
	localparam int AW = gfov_pkg::ADDR_W;
	localparam int CW = gfov_pkg::CFG_W;

	// config
	logic [CW-1:0] radius_q, width_q, height_q;
	logic [CW-1:0] w_use, h_use;

	// viewer, sweep, bounds, target
	logic [XW-1:0] px_q, sx_q, left_q, rlast_q, tx_q;
	logic [YW-1:0] py_q, sy_q, top_q, blast_q, ty_q;
	logic [11:0]   r2_q;

	// ray state
	logic [XW-1:0]      cx_q;
	logic [YW-1:0]      cy_q;
	logic signed [8:0]  err_q;
	logic [5:0]         major_q, minor_q, cnt_q;
	logic               xmaj_q, gx_nz_q, gx_neg_q, gy_nz_q, gy_neg_q, last_step_q;

	logic      out_valid_q;
	gfov_pkg::item_out_t out_q;

	logic trans_rd, vis_rd, exp_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CW'(8);
			width_q  <= CW'(64);
			height_q <= CW'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				gfov_pkg::REG_RADIUS: radius_q <= cfg_data;
				gfov_pkg::REG_WIDTH:  width_q  <= cfg_data;
				gfov_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_use = (width_q > CW'(gfov_pkg::MAX_WIDTH)) ? CW'(gfov_pkg::MAX_WIDTH) : width_q;
	assign h_use = (height_q > CW'(gfov_pkg::MAX_HEIGHT)) ? CW'(gfov_pkg::MAX_HEIGHT) : height_q;

	// ---------------- sweep counters ----------------
	logic [XW-1:0] x_lim;
	logic [YW-1:0] y_lim;
	assign x_lim = cmd.sweep_init ? XW'(gfov_pkg::MAX_WIDTH - 1) : XW'(w_use - CW'(1));
	assign y_lim = cmd.sweep_init ? YW'(gfov_pkg::MAX_HEIGHT - 1) : YW'(h_use - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
		end else if (cmd.capture) begin
			sx_q <= '0;
			sy_q <= '0;
		end else if (cmd.sweep_init || cmd.sweep_clear) begin
			if (sx_q == x_lim) begin
				sx_q <= '0;
				sy_q <= sy_q + YW'(1);
			end else begin
				sx_q <= sx_q + XW'(1);
			end
		end
	end

	// ---------------- view bounds ----------------
	logic [5:0]    r6;
	logic [XW-1:0] left_c;
	logic [YW-1:0] top_c;
	logic [CW-1:0] rex, bex;
	assign r6     = radius_q[5:0];
	assign left_c = (px_q >= XW'(r6)) ? px_q - XW'(r6) : '0;
	assign top_c  = (py_q >= YW'(r6)) ? py_q - YW'(r6) : '0;
	assign rex    = CW'(px_q) + CW'(r6) + CW'(1);
	assign bex    = CW'(py_q) + CW'(r6) + CW'(1);

	// ---------------- ray setup ----------------
	logic signed [6:0] dx, dy;
	logic [5:0]        adx, ady;
	assign dx  = $signed({1'b0, tx_q}) - $signed({1'b0, px_q});
	assign dy  = $signed({1'b0, ty_q}) - $signed({1'b0, py_q});
	assign adx = dx[6] ? 6'(-dx) : 6'(dx);
	assign ady = dy[6] ? 6'(-dy) : 6'(dy);

	// ---------------- step ----------------
	logic signed [8:0] err1, err2;
	logic signed [9:0] twice;
	logic              bump, xmove, ymove;
	logic [XW-1:0]     inc_x;
	logic [YW-1:0]     inc_y;
	assign err1  = err_q + $signed({3'b0, minor_q});
	assign twice = {err1, 1'b0};
	assign bump  = twice >= $signed({4'b0, major_q});
	assign err2  = bump ? err1 - $signed({3'b0, major_q}) : err1;
	assign xmove = xmaj_q || bump;
	assign ymove = !xmaj_q || bump;
	assign inc_x = gx_nz_q ? (gx_neg_q ? '1 : XW'(1)) : '0;
	assign inc_y = gy_nz_q ? (gy_neg_q ? '1 : YW'(1)) : '0;

	// ---------------- distance check ----------------
	logic signed [6:0]  ox, oy;
	logic signed [13:0] sqx, sqy;
	logic [14:0]        sq_dist;
	assign ox      = $signed({1'b0, cx_q}) - $signed({1'b0, px_q});
	assign oy      = $signed({1'b0, cy_q}) - $signed({1'b0, py_q});
	assign sqx     = ox * ox;
	assign sqy     = oy * oy;
	assign sq_dist = 15'($unsigned(sqx)) + 15'($unsigned(sqy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0; py_q <= '0;
			left_q <= '0; top_q <= '0; rlast_q <= '0; blast_q <= '0;
			tx_q <= '0; ty_q <= '0; r2_q <= '0;
			cx_q <= '0; cy_q <= '0; err_q <= '0;
			major_q <= '0; minor_q <= '0; cnt_q <= '0;
			xmaj_q <= 1'b0; gx_nz_q <= 1'b0; gx_neg_q <= 1'b0;
			gy_nz_q <= 1'b0; gy_neg_q <= 1'b0; last_step_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				px_q <= in_data.cell_x;
				py_q <= in_data.cell_y;
			end
			if (cmd.mark_viewer) begin
				left_q  <= left_c;
				top_q   <= top_c;
				tx_q    <= left_c;
				ty_q    <= top_c;
				rlast_q <= XW'(((rex > w_use) ? w_use : rex) - CW'(1));
				blast_q <= YW'(((bex > h_use) ? h_use : bex) - CW'(1));
				r2_q    <= 12'(r6) * 12'(r6);
			end
			if (cmd.next_target) begin
				if (tx_q == rlast_q) begin
					tx_q <= left_q;
					ty_q <= ty_q + YW'(1);
				end else begin
					tx_q <= tx_q + XW'(1);
				end
			end
			if (cmd.ray_init) begin
				cx_q     <= px_q;
				cy_q     <= py_q;
				err_q    <= '0;
				cnt_q    <= '0;
				xmaj_q   <= !(ady > adx);
				major_q  <= (ady > adx) ? ady : adx;
				minor_q  <= (ady > adx) ? adx : ady;
				gx_nz_q  <= dx != '0;
				gx_neg_q <= dx[6];
				gy_nz_q  <= dy != '0;
				gy_neg_q <= dy[6];
			end
			if (cmd.step) begin
				cx_q        <= xmove ? cx_q + inc_x : cx_q;
				cy_q        <= ymove ? cy_q + inc_y : cy_q;
				err_q       <= err2;
				last_step_q <= cnt_q == major_q;
				cnt_q       <= cnt_q + 6'd1;
			end
		end
	end

	// ---------------- stores ----------------
	logic          mark_any, sweep_any;
	logic [AW-1:0] q_addr, mark_addr;
	assign mark_any  = cmd.mark_viewer || cmd.mark_ray;
	assign sweep_any = cmd.sweep_init || cmd.sweep_clear;
	assign q_addr    = gfov_pkg::cell_addr(in_data.cell_x, in_data.cell_y);
	assign mark_addr = sweep_any ? gfov_pkg::cell_addr(sx_q, sy_q) :
		cmd.mark_viewer ? gfov_pkg::cell_addr(px_q, py_q) : gfov_pkg::cell_addr(cx_q, cy_q);

	gfov_ram #(.WIDTH(1), .DEPTH(gfov_pkg::CELLS)) u_trans (
		.clk     (clk),
		.wr_en   (cmd.load_tile),
		.wr_addr (q_addr),
		.wr_data (in_data.see_through),
		.rd_addr (gfov_pkg::cell_addr(cx_q, cy_q)),
		.rd_data (trans_rd)
	);

	gfov_ram #(.WIDTH(1), .DEPTH(gfov_pkg::CELLS)) u_vis (
		.clk     (clk),
		.wr_en   (sweep_any || mark_any),
		.wr_addr (mark_addr),
		.wr_data (mark_any),
		.rd_addr (q_addr),
		.rd_data (vis_rd)
	);

	gfov_ram #(.WIDTH(1), .DEPTH(gfov_pkg::CELLS)) u_exp (
		.clk     (clk),
		.wr_en   (cmd.sweep_init || mark_any),
		.wr_addr (mark_addr),
		.wr_data (mark_any),
		.rd_addr (q_addr),
		.rd_data (exp_rd)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.is_visible  <= cmd.out_query && vis_rd;
			out_q.is_explored <= cmd.out_query && exp_rd;
			out_q.bad_coord   <= cmd.out_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- status ----------------
	assign st.mode        = in_data.mode;
	assign st.in_bad      = (CW'(in_data.cell_x) >= w_use) || (CW'(in_data.cell_y) >= h_use);
	assign st.out_busy    = out_valid_q && !out_ready;
	assign st.sweep_last  = (sx_q == x_lim) && (sy_q == y_lim);
	assign st.radius_neg  = radius_q[CW-1];
	assign st.check_stop  = (sq_dist > 15'(r2_q)) || (CW'(cx_q) >= w_use) ||
		(CW'(cy_q) >= h_use);
	assign st.mark_stop   = !trans_rd || ((cx_q == tx_q) && (cy_q == ty_q)) || last_step_q;
	assign st.target_last = (tx_q == rlast_q) && (ty_q == blast_q);

endmodule
`default_nettype wire

@@ src/grid_fov_bresenham_raycast_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grid_fov_bresenham_raycast_top: grid field-of-view engine
// Tile transparency load, Bresenham ray-cast view and cell mark query over a
// 64 x 64 map.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | to block  | in_valid / in_ready    | item_in_t (mode, x, y, st)
//   out     | from block| out_valid / out_ready  | item_out_t (vis, expl, bad)
//   cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Load, bad-coordinate and unused-mode items finish at dispatch; a query
// reads the stores first. View: dispatch, visible clear, viewer mark, then
// per ray a setup and Bresenham steps (step, check, mark), then the result;
// a negative radius goes from the clear to the result. After reset the block
// clears the visible and explored stores before in_ready rises. cfg_ready is
// always high. A stalled result holds the block at idle; input waits until
// the result register frees up.
// ---------------------------------------------------------------------------
module grid_fov_bresenham_raycast_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire gfov_pkg::item_in_t             in_data,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      gfov_pkg::item_out_t            out_data,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [gfov_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [gfov_pkg::CFG_W-1:0]     cfg_data
);

	gfov_pkg::gfov_cmd_t  cmd;
	gfov_pkg::gfov_stat_t st;

	// config writes are taken in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: reset clear, item dispatch, ray walk
	gfov_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, stepper, distance check, result register
	gfov_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire
